[rtl/sql_gap_skip_scanner_unit_macros.svh]
// Assertion helpers shared by the scanner RTL.
`ifndef SQL_GAP_SKIP_SCANNER_UNIT_MACROS_SVH
`define SQL_GAP_SKIP_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SGS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sgs_pkg.sv]
`timescale 1ns / 1ps

package sgs_pkg;

  // Width of the internal skipped-byte counter; it saturates at all ones.
  localparam int LENGTH_BITS = 16;
  localparam int FieldBits   = 16;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_SLASH_STAR = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_DASH       = 3'd5,
    MODE_LINE       = 3'd6
  } scan_mode_t;

  typedef logic [LENGTH_BITS-1:0] run_len_t;

  typedef struct packed {
    logic [FieldBits-1:0] skipped_length;
    logic                 unclosed_comment;
    logic                 ended_at_text_end;
  } result_t;

  // Clamp the counter into the 16-bit result field.
  function automatic logic [FieldBits-1:0] clamp_field(run_len_t v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > 33'({FieldBits{1'b1}})) begin
      return {FieldBits{1'b1}};
    end
    return wide[FieldBits-1:0];
  endfunction

endpackage

[rtl/sql_gap_skip_scanner_unit.sv]
`timescale 1ns / 1ps
`include "sql_gap_skip_scanner_unit_macros.svh"

// SQL gap skip scanner. Feed the bytes of the gap between two SQL tokens, one
// beat per byte, with end_of_text set on the final byte of the text. The unit
// counts leading whitespace (space, tab, CR, FF, and LF when newline_is_space
// is 1), closed /*...*/ comments and -- line comments, and delivers one
// result beat when the run ends: at the first significant byte or at end of
// text. A block comment that never closes is left out of the length and flags
// unclosed_comment. A slash or dash whose meaning depends on the next byte is
// decided one byte later; after a significant byte the unit starts afresh
// for the next gap with the byte that follows. Throughput is one byte per
// clock while text_stall is low: the byte classifier is a single pass of
// logic between the mode and counter registers and the result register. A
// result beat is loaded into the result register, or while the sink stalls
// into a one-entry skid stage behind it, before it shows on the result port;
// text_stall is a registered signal that rises only when both the result
// register and the skid stage are full. newline_is_space may be written at
// any time the unit is idle; cfg_ready is always high.
module sql_gap_skip_scanner_unit (
  input  logic       clk,
  input  logic       rst,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       newline_is_space,

  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,

  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] skipped_length,
  output logic        unclosed_comment,
  output logic        ended_at_text_end
);

  // Configuration register.
  logic nl_space;

  // Scan state.
  sgs_pkg::scan_mode_t mode, mode_next;
  sgs_pkg::run_len_t   run_length, run_length_next;
  sgs_pkg::run_len_t   length_before_comment, length_before_comment_next;

  // Result register and skid stage.
  sgs_pkg::result_t out_res;
  sgs_pkg::result_t skid_res;
  logic             skid_valid;

  sgs_pkg::result_t  res_next;
  sgs_pkg::run_len_t bumped;
  logic              emit;
  logic              accept;
  logic              out_free;
  logic              is_ws;
  logic              is_star;
  logic              is_slash;
  logic              is_dash;

  assign cfg_ready  = 1'b1;
  assign text_stall = skid_valid;
  assign accept     = text_valid && !text_stall;
  assign out_free   = !result_valid || !result_stall;

  assign skipped_length    = out_res.skipped_length;
  assign unclosed_comment  = out_res.unclosed_comment;
  assign ended_at_text_end = out_res.ended_at_text_end;

  // Byte classes.
  assign is_star  = (text_byte == sgs_pkg::CH_STAR);
  assign is_slash = (text_byte == sgs_pkg::CH_SLASH);
  assign is_dash  = (text_byte == sgs_pkg::CH_DASH);
  assign is_ws    = (text_byte == sgs_pkg::CH_SPACE) || (text_byte == sgs_pkg::CH_TAB) ||
                    (text_byte == sgs_pkg::CH_CR) || (text_byte == sgs_pkg::CH_FF) ||
                    ((text_byte == sgs_pkg::CH_LF) && nl_space);

  // Saturating increment of the run counter.
  assign bumped = (run_length == {sgs_pkg::LENGTH_BITS{1'b1}}) ?
                  run_length : run_length + sgs_pkg::LENGTH_BITS'(1);

  // Next scan state and result for the byte on the input port.
  always_comb begin
    mode_next                  = mode;
    run_length_next            = run_length;
    length_before_comment_next = length_before_comment;
    emit                       = 1'b0;
    res_next                   = '{skipped_length: sgs_pkg::clamp_field(run_length),
                                   unclosed_comment: 1'b0,
                                   ended_at_text_end: 1'b0};

    case (mode)
      sgs_pkg::MODE_SLASH: begin
        // A star opens a block comment only if more text follows.
        if (is_star && !end_of_text) begin
          run_length_next = bumped;
          mode_next       = sgs_pkg::MODE_SLASH_STAR;
        end else begin
          emit                    = 1'b1;
          res_next.skipped_length = sgs_pkg::clamp_field(length_before_comment);
        end
      end
      sgs_pkg::MODE_SLASH_STAR: begin
        // Opener too close to the end of text: the slash was significant.
        if (end_of_text) begin
          emit                    = 1'b1;
          res_next.skipped_length = sgs_pkg::clamp_field(length_before_comment);
        end else begin
          run_length_next = bumped;
          mode_next       = is_star ? sgs_pkg::MODE_BLOCK_STAR : sgs_pkg::MODE_BLOCK;
        end
      end
      sgs_pkg::MODE_BLOCK, sgs_pkg::MODE_BLOCK_STAR: begin
        if ((mode == sgs_pkg::MODE_BLOCK_STAR) && is_slash) begin
          // Close of the block comment.
          run_length_next = bumped;
          mode_next       = sgs_pkg::MODE_NORMAL;
          if (end_of_text) begin
            emit                       = 1'b1;
            res_next.skipped_length    = sgs_pkg::clamp_field(bumped);
            res_next.ended_at_text_end = 1'b1;
          end
        end else if (end_of_text) begin
          // Unclosed comment: drop it from the count.
          emit                       = 1'b1;
          res_next.skipped_length    = sgs_pkg::clamp_field(length_before_comment);
          res_next.unclosed_comment  = 1'b1;
          res_next.ended_at_text_end = 1'b1;
        end else begin
          run_length_next = bumped;
          mode_next       = is_star ? sgs_pkg::MODE_BLOCK_STAR : sgs_pkg::MODE_BLOCK;
        end
      end
      sgs_pkg::MODE_DASH: begin
        if (is_dash) begin
          run_length_next = bumped;
          mode_next       = sgs_pkg::MODE_LINE;
          if (end_of_text) begin
            emit                       = 1'b1;
            res_next.skipped_length    = sgs_pkg::clamp_field(bumped);
            res_next.ended_at_text_end = 1'b1;
          end
        end else begin
          emit                    = 1'b1;
          res_next.skipped_length = sgs_pkg::clamp_field(length_before_comment);
        end
      end
      sgs_pkg::MODE_LINE: begin
        // Everything through the line feed belongs to the comment.
        run_length_next = bumped;
        if (text_byte == sgs_pkg::CH_LF) begin
          mode_next = sgs_pkg::MODE_NORMAL;
        end
        if (end_of_text) begin
          emit                       = 1'b1;
          res_next.skipped_length    = sgs_pkg::clamp_field(bumped);
          res_next.ended_at_text_end = 1'b1;
        end
      end
      default: begin
        mode_next = sgs_pkg::MODE_NORMAL;
        if (is_ws) begin
          run_length_next = bumped;
          if (end_of_text) begin
            emit                       = 1'b1;
            res_next.skipped_length    = sgs_pkg::clamp_field(bumped);
            res_next.ended_at_text_end = 1'b1;
          end
        end else if ((is_slash || is_dash) && !end_of_text) begin
          // Tentative comment opener: remember where it started.
          length_before_comment_next = run_length;
          run_length_next            = bumped;
          mode_next = is_slash ? sgs_pkg::MODE_SLASH : sgs_pkg::MODE_DASH;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    // A result restarts the scan for the next gap.
    if (emit) begin
      mode_next                  = sgs_pkg::MODE_NORMAL;
      run_length_next            = '0;
      length_before_comment_next = '0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      nl_space <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      nl_space <= newline_is_space;
    end
  end

  // Scan state: advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= sgs_pkg::MODE_NORMAL;
      run_length            <= '0;
      length_before_comment <= '0;
    end else if (accept) begin
      mode                  <= mode_next;
      run_length            <= run_length_next;
      length_before_comment <= length_before_comment_next;
    end
  end

  // Result register and skid stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      result_valid <= skid_valid || (accept && emit);
      skid_valid   <= 1'b0;
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: load the result register from the skid stage first, else hold
  // a new result in the skid stage while the sink stalls.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept && emit) begin
        out_res <= res_next;
      end
    end else if (accept && emit) begin
      skid_res <= res_next;
    end
  end

  `SGS_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, result_valid, "skid full with result register empty")
  `SGS_ASSERT_NEXT(a_emit_shows, clk, rst, accept && emit, result_valid, "accepted result not presented")
  `SGS_ASSERT_IMPLY(a_opener_before_run, clk, rst, 1'b1, length_before_comment <= run_length, "comment start beyond run length")
  `SGS_ASSERT_IMPLY(a_comment_counted, clk, rst, mode != sgs_pkg::MODE_NORMAL, run_length != '0, "comment mode with empty run")

endmodule
